[rtl/pbsgc_pkg.sv]
// ----------------------------------------------------------------------------
// pbsgc_pkg: shared types and constants of the packed base store GC counter
// Item structs, command codes, base codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package pbsgc_pkg;

  localparam int unsigned FieldW = 17;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CmdW   = 2;

  // command codes
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CmdW-1:0] CMD_APPEND = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY  = 2'd2;

  // base codes
  localparam logic [CodeW-1:0] CODE_A       = 4'd0;
  localparam logic [CodeW-1:0] CODE_C       = 4'd1;
  localparam logic [CodeW-1:0] CODE_G       = 4'd2;
  localparam logic [CodeW-1:0] CODE_T       = 4'd3;
  localparam logic [CodeW-1:0] CODE_INVALID = 4'hf;

  localparam logic [CharW-1:0] CHAR_A     = 8'h41;
  localparam logic [CharW-1:0] CHAR_C     = 8'h43;
  localparam logic [CharW-1:0] CHAR_G     = 8'h47;
  localparam logic [CharW-1:0] CHAR_T     = 8'h54;
  localparam logic [CharW-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOW_Z = 8'h7a;
  localparam logic [CharW-1:0] CASE_DIFF  = 8'h20;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [CharW-1:0]  base_char;
    logic [FieldW-1:0] range_start;
    logic [FieldW-1:0] range_end;
  } in_t;

  typedef struct packed {
    logic [FieldW-1:0] gc_count;
    logic [FieldW-1:0] valid_count;
    logic              beyond_length;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic walk;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;      // query needs no walk (end past length or empty range)
    logic last_pos;  // walk pointer sits on the final position
  } sts_t;

  // upper-case and map one character to its 4-bit code
  function automatic logic [CodeW-1:0] encode_base(input logic [CharW-1:0] ch);
    logic [CharW-1:0] up;
    logic [CodeW-1:0] code;
    up = ch;
    if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
      up = ch - CASE_DIFF;
    end
    unique case (up)
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_INVALID;
    endcase
    return code;
  endfunction

endpackage

[rtl/pbsgc_dp.sv]
// ----------------------------------------------------------------------------
// pbsgc_dp: datapath of the GC counter
// Base store memory, sequence length, walk pointer, count accumulators and
// the output payload register.
// ----------------------------------------------------------------------------
module pbsgc_dp #(
  parameter int unsigned MAX_BASES = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbsgc_pkg::in_t  in_data_i,
  input  pbsgc_pkg::cmd_t cmd_i,
  output pbsgc_pkg::sts_t sts_o,
  output pbsgc_pkg::out_t out_data_o
);
  import pbsgc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BASES);
  localparam int unsigned LW = $clog2(MAX_BASES + 1);
  localparam int unsigned CW = (LW > FieldW) ? LW : FieldW;

  logic [CodeW-1:0]  mem [MAX_BASES];
  logic [LW-1:0]     len_q, len_d;
  logic [FieldW-1:0] pos_q, last_q;
  logic [FieldW-1:0] gc_q, vc_q;
  logic              beyond_q;
  logic              rd_vld_q;
  logic [CodeW-1:0]  rd_code_q;
  out_t              out_q;

  logic [FieldW-1:0] first_eff;
  logic              beyond, empty, wr_en, is_gc, is_valid;

  // query range decode from the incoming item
  assign first_eff = (in_data_i.range_start == '0) ? FieldW'(1) : in_data_i.range_start;
  assign beyond    = CW'(in_data_i.range_end) > CW'(len_q);
  assign empty     = first_eff > in_data_i.range_end;

  assign sts_o.skip     = beyond || empty;
  assign sts_o.last_pos = ((FieldW + 1)'(pos_q) + (FieldW + 1)'(1)) == (FieldW + 1)'(last_q);

  // appends past capacity are dropped
  assign wr_en = cmd_i.append && (len_q < LW'(MAX_BASES));

  always_comb begin
    len_d = len_q;
    if (cmd_i.clear) begin
      len_d = '0;
    end else if (wr_en) begin
      len_d = len_q + LW'(1);
    end
  end

  // base store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(len_q)] <= encode_base(in_data_i.base_char);
    end
    if (cmd_i.walk) begin
      rd_code_q <= mem[AW'(pos_q)];
    end
  end

  assign is_gc    = (rd_code_q == CODE_C) || (rd_code_q == CODE_G);
  assign is_valid = rd_code_q <= CODE_T;

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      rd_vld_q <= cmd_i.walk;
    end
  end

  // walk pointer, range end and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q    <= first_eff - FieldW'(1);
      last_q   <= in_data_i.range_end;
      beyond_q <= beyond;
      gc_q     <= '0;
      vc_q     <= '0;
    end else begin
      if (cmd_i.walk) begin
        pos_q <= pos_q + FieldW'(1);
      end
      if (rd_vld_q) begin
        gc_q <= gc_q + FieldW'(is_gc);
        vc_q <= vc_q + FieldW'(is_valid);
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.gc_count      <= gc_q;
      out_q.valid_count   <= vc_q;
      out_q.beyond_length <= beyond_q;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // stored length never passes capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_BASES))
    else $error("sequence length beyond capacity");
`endif

endmodule

[rtl/pbsgc_ctrl.sv]
// ----------------------------------------------------------------------------
// pbsgc_ctrl: controller of the GC counter
// Decodes commands, sequences the walk over the store and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module pbsgc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pbsgc_pkg::CmdW-1:0]    command_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  pbsgc_pkg::sts_t               sts_i,
  output pbsgc_pkg::cmd_t               cmd_o
);
  import pbsgc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (command_i)
            CMD_CLEAR:  cmd_o.clear  = 1'b1;
            CMD_APPEND: cmd_o.append = 1'b1;
            CMD_QUERY: begin
              cmd_o.start = 1'b1;
              state_d     = sts_i.skip ? ST_DONE : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.last_pos) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // an accepted query always takes the block out of idle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i == CMD_QUERY) |=> !in_ready_o)
    else $error("query did not leave idle");

  // a result is only loaded into a free or draining output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output overwritten");
`endif

endmodule

[rtl/packed_base_store_gc_counter_top.sv]
// Clear and append: one item per cycle while no query is in progress, done at the accept edge.
// Query whose range end is past the stored length, or with an empty range:
//   result loaded from the done state once the output register is free.
// Query over N positions: the walk state reads the base store one position
//   per cycle through its single read port, then flush and done load the result.
// The block takes no new item until a query's result sits in the output reg.
// Reset clears the length and control state at once; the store is not swept.
// ----------------------------------------------------------------------------
// packed_base_store_gc_counter_top: GC content counter over a stored sequence
// Stores appended bases as 4-bit codes and counts C/G and ACGT bases over a
// 1-based inclusive range on request.
// ----------------------------------------------------------------------------
module packed_base_store_gc_counter_top #(
  parameter int unsigned MAX_BASES = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pbsgc_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbsgc_pkg::out_t out_data_o
);
  import pbsgc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pbsgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (in_data_i.command),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pbsgc_dp #(
    .MAX_BASES (MAX_BASES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // an out-of-length result carries zero counts
  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.beyond_length) |->
      (out_data_o.gc_count == '0 && out_data_o.valid_count == '0))
    else $error("nonzero counts with beyond_length");

  // C/G bases are a subset of valid bases
  a_gc_le_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.gc_count <= out_data_o.valid_count))
    else $error("gc_count above valid_count");
`endif

endmodule
